// ===== rtl/core/sdp_pkg.sv =====
package sdp_pkg;

  localparam int SetBitsDef   = 10;
  localparam int WaysDef      = 4;
  localparam int SqDepthDef   = 256;

  localparam logic [1:0] ActPredict = 2'd0;
  localparam logic [1:0] ActTrain   = 2'd1;
  localparam logic [1:0] ActCommit  = 2'd2;

  localparam logic [2:0] CfgTagBits = 3'd0;
  localparam logic [2:0] CfgMaxConf = 3'd1;
  localparam logic [2:0] CfgThresh  = 3'd2;
  localparam logic [2:0] CfgIncr    = 3'd3;
  localparam logic [2:0] CfgDecr    = 3'd4;
  localparam logic [2:0] CfgLimit   = 3'd5;

  // one stored way
  typedef struct packed {
    logic        valid;
    logic [62:0] tag;
    logic [8:0]  dist0;
    logic [8:0]  dist1;
    logic [7:0]  conf;
    logic [63:0] stamp;
  } entry_t;

  // xor fold of key p and hash h at width w (w of 0 gives 0)
  // every chunk of the hash is shifted down on its own, so the chunks fold in parallel
  function automatic logic [62:0] fold_key(logic [63:0] p, logic [63:0] h, logic [5:0] w);
    logic [63:0] mask;
    logic [63:0] acc;
    logic [11:0] sh;
    if (w == 6'd0) return '0;
    mask = (64'd1 << w) - 64'd1;
    acc  = (h ^ p) & mask;
    for (int i = 1; i < 64; i++) begin
      sh = 12'(i) * {6'd0, w};
      if (sh < 12'd64) acc = acc ^ ((h >> sh) & mask);
    end
    return acc[62:0];
  endfunction

endpackage

// ===== rtl/core/sdp_way_mem.sv =====
module sdp_way_mem #(
  parameter int SetBits = sdp_pkg::SetBitsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [SetBits-1:0]   waddr_i,
  input  sdp_pkg::entry_t      wdata_i,
  input  logic [SetBits-1:0]   raddr_i,
  output sdp_pkg::entry_t      rdata_o
);
  import sdp_pkg::*;

  entry_t mem_q [2**SetBits];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/store_distance_predictor_table_unit.sv =====
// store distance predictor table
// an accepted item passes the read and resolve states before its result is registered
// a new item is taken only after the last one has left resolve, as it does the read-modify-write of the way memories
// a result left waiting holds the next item in resolve, which then stalls the input
// reset: clearing pass over all 2**SET_IDX_W sets after reset, one set a cycle, no item taken meanwhile
// configuration registers return to their defaults on reset
module store_distance_predictor_table_unit #(
  parameter int SET_IDX_W         = sdp_pkg::SetBitsDef,
  parameter int WAYS              = sdp_pkg::WaysDef,
  parameter int STORE_QUEUE_DEPTH = sdp_pkg::SqDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // load_pc[63:0], path_hash[127:64], distance[135:128], mispredict[136]
  input  logic [143:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // first_distance[8:0], second_distance[17:9]
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i
);
  import sdp_pkg::*;

  localparam int WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [9:0] HalfDepth = 10'(STORE_QUEUE_DEPTH / 2);

  // sequencer codes
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StRes   = 3'd3;

  logic [2:0] state_q, state_d;

  // configuration
  logic [5:0] tag_bits_q;
  logic [7:0] max_conf_q, thresh_q, incr_q, decr_q;
  logic [8:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_bits_q <= 6'd16;
      max_conf_q <= 8'd7;
      thresh_q   <= 8'd4;
      incr_q     <= 8'd1;
      decr_q     <= 8'd1;
      limit_q    <= 9'd128;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTagBits: tag_bits_q <= cfg_data_i[5:0];
        CfgMaxConf: max_conf_q <= cfg_data_i[7:0];
        CfgThresh:  thresh_q   <= cfg_data_i[7:0];
        CfgIncr:    incr_q     <= cfg_data_i[7:0];
        CfgDecr:    decr_q     <= cfg_data_i[7:0];
        CfgLimit:   limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item registers
  logic [1:0]           act_q;
  logic [7:0]           dist_q;
  logic                 wrong_q;
  logic [SET_IDX_W-1:0] set_q;
  logic [62:0]          tag_q;
  logic [63:0]          stamp_ctr_q;
  logic [SET_IDX_W-1:0] clr_q;
  logic [17:0]          res_q;
  logic                 out_valid_q;

  logic [63:0] pc_in, h_in, p_set, p_tag;
  logic [62:0] set_fold;
  assign pc_in    = s_axis_tdata[63:0];
  assign h_in     = s_axis_tdata[127:64];
  assign p_set    = pc_in ^ (pc_in >> 2) ^ (pc_in >> 5);
  assign p_tag    = pc_in ^ (pc_in >> 3) ^ (pc_in >> 7);
  assign set_fold = fold_key(p_set, h_in, 6'(SET_IDX_W));

  logic in_acc;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // resolve may retire once the output register is free or being emptied
  logic res_go;
  assign res_go = !out_valid_q || m_axis_tready;

  // way memories
  entry_t rd   [WAYS];
  entry_t wr_e;
  logic [WAYS-1:0] we;
  logic [SET_IDX_W-1:0] waddr;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    sdp_way_mem #(.SetBits(SET_IDX_W)) u_mem (
      .clk_i   (clk_i),
      .we_i    (we[w]),
      .waddr_i (waddr),
      .wdata_i (wr_e),
      .raddr_i (set_q),
      .rdata_o (rd[w])
    );
  end

  // resolve: hit search, victim choice, result and update
  logic               hit;
  logic [WayBits-1:0] hit_w, vic_w, tgt_w;
  logic               inv_found;
  entry_t             cur, upd;
  logic [17:0]        res_d;
  logic [9:0]         lim;
  logic [8:0]         csum;
  logic               do_write;

  always_comb begin
    hit = 1'b0; hit_w = '0; inv_found = 1'b0; vic_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd[w].valid && rd[w].tag == tag_q) begin
        hit = 1'b1; hit_w = WayBits'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!rd[w].valid) begin
        inv_found = 1'b1; vic_w = WayBits'(w);
      end
    end
    if (!inv_found) begin
      vic_w = '0;
      for (int w = 1; w < WAYS; w++) begin
        if (rd[w].stamp < rd[vic_w].stamp) vic_w = WayBits'(w);
      end
    end
    tgt_w    = hit ? hit_w : vic_w;
    cur      = rd[tgt_w];
    upd      = cur;
    res_d    = '1;
    do_write = 1'b0;
    lim      = (limit_q == 9'd0) ? HalfDepth : {1'b0, limit_q};
    csum     = {1'b0, cur.conf} + {1'b0, incr_q};
    case (act_q)
      ActPredict: begin
        if (hit && cur.conf >= thresh_q && !(cur.dist0[8] && cur.dist1[8]))
          res_d = {cur.dist1, cur.dist0};
      end
      ActTrain: begin
        do_write = 1'b1;
        if (!hit) begin
          upd.valid = 1'b1;
          upd.tag   = tag_q;
          upd.dist0 = {1'b0, dist_q};
          upd.dist1 = '1;
        end else if (cur.dist1[8] && cur.dist0 != {1'b0, dist_q} &&
                     {2'b0, dist_q} < lim && !cur.dist0[8] && {1'b0, cur.dist0} < lim) begin
          upd.dist1 = {1'b0, dist_q};
        end else begin
          upd.dist0 = {1'b0, dist_q};
          upd.dist1 = '1;
        end
        upd.conf  = max_conf_q;
        upd.stamp = stamp_ctr_q;
      end
      ActCommit: begin
        if (hit && cur.conf != 8'd0) begin
          do_write = 1'b1;
          if (wrong_q)
            upd.conf = (cur.conf > decr_q) ? cur.conf - decr_q : 8'd0;
          else if (incr_q == 8'd0 || csum > {1'b0, max_conf_q})
            upd.conf = max_conf_q;
          else
            upd.conf = csum[7:0];
          upd.stamp = stamp_ctr_q;
        end
      end
      default: ;
    endcase
  end

  // note: entries with a negative first distance never meet the limit test
  always_comb begin
    we    = '0;
    waddr = set_q;
    wr_e  = upd;
    if (state_q == StClear) begin
      we    = '1;
      waddr = clr_q;
      wr_e  = '0;
      wr_e.dist0 = '1;
      wr_e.dist1 = '1;
    end else if (state_q == StRes && do_write && res_go) begin
      we[tgt_w] = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == '1) state_d = StIdle;
      StIdle:  if (in_acc) state_d = StRead;
      StRead:  state_d = StRes;
      StRes:   if (res_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      stamp_ctr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (state_q == StRes && do_write && res_go) stamp_ctr_q <= stamp_ctr_q + 64'd1;
      if (state_q == StRes && res_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= s_axis_tuser;
      dist_q  <= s_axis_tdata[135:128];
      wrong_q <= s_axis_tdata[136];
      set_q   <= set_fold[SET_IDX_W-1:0];
      tag_q   <= fold_key(p_tag, h_in, tag_bits_q);
    end
    if (state_q == StRes && res_go) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

  // result only after a resolve step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == StRes)
    else $error("result without resolve");

  // no item taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !s_axis_tready)
    else $error("ready during clear");

  // stamp holds outside resolve and advances only on a table write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StRes |=> $stable(stamp_ctr_q))
    else $error("stamp moved");

  // a waiting result holds steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while waiting");

endmodule

// ===== dv/sdp_checker.sv =====
`timescale 1ns / 100ps

// watches the item, result and register channels, predicts each result and compares
module sdp_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  output int           pending_o,
  output int           fail_count_o,
  output int           result_count_o,
  output int           hit_count_o
);
  import sdp_pkg::*;

  localparam int NumSets = 1 << SetBitsDef;

  typedef struct {
    bit              valid;
    bit [62:0]       tag;
    int              dist0;
    int              dist1;
    int unsigned     conf;
    longint unsigned stamp;
  } way_rec_t;

  way_rec_t        ways_mem[NumSets * WaysDef];
  longint unsigned stamp_ctr;
  int unsigned     tag_width, conf_max, conf_thresh, conf_inc, conf_dec, dist_limit;
  bit [17:0]       distance_q[$];

  function automatic bit [63:0] xor_fold(bit [63:0] p, bit [63:0] h, int unsigned w);
    bit [63:0] mask, acc;
    if (w == 0 || w > 63) return '0;
    mask = (64'd1 << w) - 64'd1;
    acc  = (h ^ p) & mask;
    h    = h >> w;
    while (h != 0) begin
      acc ^= h & mask;
      h = h >> w;
    end
    return acc;
  endfunction

  function automatic int set_base(bit [63:0] pc, bit [63:0] h);
    return int'(xor_fold(pc ^ (pc >> 2) ^ (pc >> 5), h, SetBitsDef)) * WaysDef;
  endfunction

  function automatic bit [62:0] tag_for(bit [63:0] pc, bit [63:0] h);
    bit [63:0] t;
    t = xor_fold(pc ^ (pc >> 3) ^ (pc >> 7), h, tag_width);
    return t[62:0];
  endfunction

  function automatic int find_way(bit [63:0] pc, bit [63:0] h);
    int        base;
    bit [62:0] tg;
    base = set_base(pc, h);
    tg   = tag_for(pc, h);
    for (int w = 0; w < WaysDef; w++)
      if (ways_mem[base + w].valid && ways_mem[base + w].tag == tg) return base + w;
    return -1;
  endfunction

  function automatic int pick_victim(int base);
    int best;
    best = 0;
    for (int w = 0; w < WaysDef; w++)
      if (!ways_mem[base + w].valid) return base + w;
    for (int w = 1; w < WaysDef; w++)
      if (ways_mem[base + w].stamp < ways_mem[base + best].stamp) best = w;
    return base + best;
  endfunction

  // applies one item to the table copy and returns {second, first}
  function automatic bit [17:0] predict_distances(bit [1:0] act, bit [143:0] d);
    bit [63:0]   pc, h;
    int          sq_dist, lim, e;
    bit          wrong;
    int          r0, r1;
    int unsigned c;
    pc      = d[63:0];
    h       = d[127:64];
    sq_dist = int'(d[135:128]);
    wrong   = d[136];
    r0      = -1;
    r1      = -1;
    e       = find_way(pc, h);
    if (act == ActPredict) begin
      if (e >= 0 && ways_mem[e].conf >= conf_thresh &&
          !(ways_mem[e].dist0 < 0 && ways_mem[e].dist1 < 0)) begin
        r0 = ways_mem[e].dist0;
        r1 = ways_mem[e].dist1;
      end
    end else if (act == ActTrain) begin
      lim = (dist_limit == 0) ? SqDepthDef / 2 : int'(dist_limit);
      if (e < 0) begin
        e = pick_victim(set_base(pc, h));
        ways_mem[e].valid = 1'b1;
        ways_mem[e].tag   = tag_for(pc, h);
        ways_mem[e].dist0 = sq_dist;
        ways_mem[e].dist1 = -1;
      end else if (ways_mem[e].dist1 < 0 && ways_mem[e].dist0 != sq_dist &&
                   sq_dist < lim && ways_mem[e].dist0 < lim) begin
        ways_mem[e].dist1 = sq_dist;
      end else begin
        ways_mem[e].dist0 = sq_dist;
        ways_mem[e].dist1 = -1;
      end
      ways_mem[e].conf  = conf_max;
      ways_mem[e].stamp = stamp_ctr;
      stamp_ctr++;
    end else if (act == ActCommit) begin
      if (e >= 0 && ways_mem[e].conf != 0) begin
        c = ways_mem[e].conf;
        if (wrong) c = (c > conf_dec) ? c - conf_dec : 0;
        else if (conf_inc == 0) c = conf_max;
        else begin
          c += conf_inc;
          if (c > conf_max) c = conf_max;
        end
        ways_mem[e].conf  = c & 8'hff;
        ways_mem[e].stamp = stamp_ctr;
        stamp_ctr++;
      end
    end
    return {r1[8:0], r0[8:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit [17:0] want;
    if (!rst_ni) begin
      foreach (ways_mem[i]) ways_mem[i] = '{1'b0, '0, -1, -1, 0, 0};
      stamp_ctr   = 0;
      tag_width   = 16;
      conf_max    = 7;
      conf_thresh = 4;
      conf_inc    = 1;
      conf_dec    = 1;
      dist_limit  = 128;
      distance_q.delete();
      fail_count_o   <= 0;
      result_count_o <= 0;
      hit_count_o    <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgTagBits: tag_width   = cfg_data_i[5:0];
          CfgMaxConf: conf_max    = cfg_data_i[7:0];
          CfgThresh:  conf_thresh = cfg_data_i[7:0];
          CfgIncr:    conf_inc    = cfg_data_i[7:0];
          CfgDecr:    conf_dec    = cfg_data_i[7:0];
          CfgLimit:   dist_limit  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count_o <= result_count_o + 1;
        if (m_axis_tdata[8:0] != 9'h1ff) hit_count_o <= hit_count_o + 1;
        if (distance_q.size() == 0) begin
          $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = distance_q.pop_front();
          if (m_axis_tdata[8:0] != want[8:0] || m_axis_tdata[17:9] != want[17:9]) begin
            $display("%0t: distances expected first %0d second %0d, got first %0d second %0d",
                     $time, $signed(want[8:0]), $signed(want[17:9]),
                     $signed(m_axis_tdata[8:0]), $signed(m_axis_tdata[17:9]));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        distance_q.insert(distance_q.size(), predict_distances(s_axis_tuser, s_axis_tdata));
      pending_o <= distance_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sdp_pkg::*;

  localparam logic [1:0] ActUnused  = 2'd3;
  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;
  localparam int         IdleLimit  = 4000;  // covers the clearing pass and the long hold
  localparam int         HoldCycles = 200;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [8:0]   cfg_data_i;

  int pending, fail_count, result_count, hit_count;
  int setting_count;
  bit gaps_on;       // sender and receiver insert random gaps only while set
  bit hold_request;  // asks the receiver for one long hold-off

  // keys sharing a set: x and x<<10 cancel in the set fold but not in the tag fold
  logic [63:0] pool_pc[12];
  logic [63:0] pool_hash[12];

  store_distance_predictor_table_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sdp_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count),
    .result_count_o(result_count), .hit_count_o(hit_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: cycles in a row with no handshake on any channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
    end
  end

  // item as {tdata, tuser}
  function automatic logic [145:0] pack_item(logic [1:0] act, logic [63:0] pc,
                                             logic [63:0] hash, logic [7:0] sq_dist,
                                             logic wrong);
    return {7'd0, wrong, sq_dist, hash, pc, act};
  endfunction

  // called and returns at a rising edge; the item is taken at the returning edge
  task automatic send_item(logic [145:0] item);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= item[1:0];
    s_axis_tdata  <= item[145:2];
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
  endtask

  // drop valid, let every result drain, then let the pipeline settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [5:0] tb_w, logic [7:0] mx, logic [7:0] th,
                               logic [7:0] inc, logic [7:0] dec, logic [8:0] lim);
    drain();
    write_reg(CfgTagBits, {3'd0, tb_w});
    write_reg(CfgMaxConf, {1'b0, mx});
    write_reg(CfgThresh, {1'b0, th});
    write_reg(CfgIncr, {1'b0, inc});
    write_reg(CfgDecr, {1'b0, dec});
    write_reg(CfgLimit, lim);
    // spare indexes must be ignored
    write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, 9'($urandom));
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  task automatic random_items(int count);
    logic [1:0]  act;
    logic [63:0] pc, hash;
    logic [7:0]  sq_dist;
    int          k, pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        k    = $urandom_range(0, 11);
        pc   = pool_pc[k];
        hash = pool_hash[k];
      end else begin
        pc   = {$urandom, $urandom};
        hash = {$urandom, $urandom};
      end
      pick    = $urandom_range(0, 99);
      act     = pick < 35 ? ActPredict : pick < 65 ? ActTrain : pick < 95 ? ActCommit : ActUnused;
      sq_dist = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      send_item(pack_item(act, pc, hash, sq_dist, 1'($urandom)));
    end
  endtask

  initial begin
    logic [63:0] pc_a, h_a, x;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    setting_count = 1;
    for (int k = 0; k < 12; k++) begin
      x = 64'($urandom_range(1, 1023));
      pool_pc[k]   = (k < 6) ? 64'h0000_0000_0040_1a30 : 64'hffff_8000_1234_5678;
      pool_hash[k] = ((k < 6) ? 64'h5a5a_0f0f_3c3c_9696 : 64'h0123_4567_89ab_cdef)
                     ^ x ^ (x << 10);
    end
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    pc_a = pool_pc[0];
    h_a  = pool_hash[0];
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));     // empty table misses
    send_item(pack_item(ActTrain, pc_a, h_a, 8'd5, 1'b0));       // install
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));
    send_item(pack_item(ActTrain, pc_a, h_a, 8'd9, 1'b0));       // second distance added
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));
    send_item(pack_item(ActTrain, pc_a, h_a, 8'd200, 1'b0));     // full, so replaced
    send_item(pack_item(ActTrain, pc_a, h_a, 8'd100, 1'b0));     // old one above limit
    send_item(pack_item(ActTrain, pc_a, h_a, 8'd100, 1'b0));     // same distance again
    repeat (4) send_item(pack_item(ActCommit, pc_a, h_a, 8'd0, 1'b1));
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));     // below threshold
    send_item(pack_item(ActCommit, pc_a, h_a, 8'd0, 1'b0));
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));
    send_item(pack_item(ActCommit, 64'h1, 64'h2, 8'd0, 1'b0));   // commit on a miss
    send_item(pack_item(ActUnused, pc_a, h_a, 8'hff, 1'b1));
    for (int k = 1; k < 6; k++)                                  // overfill one set
      send_item(pack_item(ActTrain, pool_pc[k], pool_hash[k], 8'(k), 1'b0));
    send_item(pack_item(ActPredict, pc_a, h_a, 8'd0, 1'b0));     // oldest way evicted
    send_item(pack_item(ActTrain, '1, '1, 8'hff, 1'b1));
    send_item(pack_item(ActPredict, '1, '1, 8'd0, 1'b0));
    send_item(pack_item(ActPredict, '0, '0, 8'd0, 1'b0));

    random_items(120);

    // wide tag fold off, high ceiling, set-to-max increment, default limit
    apply_setting(6'd0, 8'd255, 8'd1, 8'd0, 8'd255, 9'd0);
    hold_request = 1'b1;  // receiver holds off while the sender keeps offering items
    random_items(130);

    // widest tag, ceiling 1 clamps old confidences, top threshold, limit 256
    gaps_on = 1'b0;
    apply_setting(6'd63, 8'd1, 8'd255, 8'd255, 8'd0, 9'd256);
    random_items(80);
    gaps_on = 1'b1;

    // zero threshold, tiny limit
    apply_setting(6'd4, 8'd3, 8'd0, 8'd2, 8'd1, 9'd1);
    random_items(130);

    for (int p = 0; p < 2; p++) begin
      apply_setting(6'($urandom), 8'($urandom), 8'($urandom_range(0, 8)),
                    8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 9'($urandom));
      random_items(130);
    end

    drain();
    $display("run covered %0d results (%0d returning a distance) over %0d register settings",
             result_count, hit_count, setting_count);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
